/* hdl/ocd_pkg.sv */
// Shared types and constants for the outcode classifier and DDA line drawer.
// Used by the front end, the back end, the checker and the top level; depends on nothing else.
`default_nettype none

package ocd_pkg;

    localparam int CLASS_W     = 2;
    localparam int CODE_W      = 4;
    localparam int COLOR_W     = 4;
    localparam int CFG_INDEX_W = 3;

    // Outcode bit positions.
    localparam int OC_LEFT  = 0;
    localparam int OC_RIGHT = 1;
    localparam int OC_BELOW = 2;
    localparam int OC_ABOVE = 3;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef enum logic [CLASS_W-1:0] {
        CLASS_VISIBLE   = 2'd0,
        CLASS_REJECTED  = 2'd1,
        CLASS_CANDIDATE = 2'd2
    } line_class_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_X_MIN     = 3'd0,
        REG_Y_MIN     = 3'd1,
        REG_X_MAX     = 3'd2,
        REG_Y_MAX     = 3'd3,
        REG_VIS_COLOR = 3'd4,
        REG_REJ_COLOR = 3'd5
    } cfg_reg_t;

    // Classified command passed from the front end to the back end.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CODE_W-1:0]  code_end;
        logic [CODE_W-1:0]  code_start;
        line_class_t        line_class;
        logic               action;
    } cmd_ctrl_t;

    localparam int CMD_CTRL_W = $bits(cmd_ctrl_t);

endpackage

`default_nettype wire

/* hdl/outcode_classify_dda_line_drawer_core.sv */
// Outcode line classifier with a fixed-point DDA pixel stepper. Every input item gives exactly
// one result. A start item (tuser low) is classified against the window registers and sets up
// the line; each step item (tuser high) then yields one pixel until the run is spent, after
// which steps report done with tlast high. Step items are handled back to back, so pixels stream
// at one per clock while m_axis_tready stays high. A start item for a visible or rejected line
// of nonzero length holds the back end until the two bit-serial increment dividers, which produce
// one quotient bit per cycle, are done and the output is free; other start items are not held.
// A queue of QUEUE_DEPTH commands sits between the classifier and the stepper, so the input
// keeps accepting items while a division runs, until it fills. The user must write window and
// colour registers through the cfg port only while the block is idle (not enforced by the block);
// cfg_ready is always high. Depends on ocd_pkg, ocd_front, ocd_fifo, ocd_back and ocd_div.
`default_nettype none

module outcode_classify_dda_line_drawer_core
    import ocd_pkg::*;
#(
    parameter int COORD_BITS  = 10,
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COORD_BITS-1:0]  cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // x_start, y_start, x_end, y_end, zero padding
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  wire logic [0:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // line_class, code_start, code_end, pixel_x, pixel_y, pixel_color, zero padding
    output logic [((2*COORD_BITS+CLASS_W+2*CODE_W+COLOR_W+7)/8)*8-1:0] m_axis_tdata,
    // pixel_valid
    output logic [0:0]                  m_axis_tuser,
    output logic                        m_axis_tlast
);

    localparam int COORDS_W     = 4 * COORD_BITS;
    localparam int OUT_FIELDS_W = 2*COORD_BITS + CLASS_W + 2*CODE_W + COLOR_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int QUEUE_W      = CMD_CTRL_W + COORDS_W;

    cmd_ctrl_t             push_ctrl, pop_ctrl;
    logic [COORDS_W-1:0]   push_coords, pop_coords;
    logic                  q_push, q_full, q_pop, q_valid;
    logic [QUEUE_W-1:0]    q_rd_data;
    line_class_t           out_class;
    logic [CODE_W-1:0]     out_code_s, out_code_e;
    logic                  out_pv;
    logic [COORD_BITS-1:0] out_px, out_py;
    logic [COLOR_W-1:0]    out_color;
    logic [OUT_FIELDS_W-1:0] out_fields;

    ocd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_action  (s_axis_tuser[0]),
        .s_coords  (s_axis_tdata[COORDS_W-1:0]),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_ctrl    (push_ctrl),
        .q_coords  (push_coords)
    );

    ocd_fifo #(
        .WIDTH (QUEUE_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data ({push_coords, push_ctrl}),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rd_data (q_rd_data)
    );

    assign pop_ctrl   = cmd_ctrl_t'(q_rd_data[CMD_CTRL_W-1:0]);
    assign pop_coords = q_rd_data[CMD_CTRL_W +: COORDS_W];

    ocd_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_ctrl        (pop_ctrl),
        .q_coords      (pop_coords),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .m_line_class  (out_class),
        .m_code_start  (out_code_s),
        .m_code_end    (out_code_e),
        .m_pixel_valid (out_pv),
        .m_pixel_x     (out_px),
        .m_pixel_y     (out_py),
        .m_pixel_color (out_color),
        .m_last_pixel  (m_axis_tlast)
    );

    assign out_fields      = {out_color, out_py, out_px, out_code_e, out_code_s, out_class};
    assign m_axis_tdata    = OUT_W'(out_fields);
    assign m_axis_tuser[0] = out_pv;

endmodule

`default_nettype wire

/* hdl/ocd_fifo.sv */
// Short command queue between the front and back ends, built from registers.
// Generic in width and depth; uses no package.
`default_nettype none

module ocd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic [WIDTH-1:0]      rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointers wrap at the last entry, so the depth need not be a power of two.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

/* hdl/ocd_front.sv */
// Front end: window and colour registers, outcode computation and line classification.
// Depends on ocd_pkg; feeds classified commands into the command queue.
`default_nettype none

module ocd_front
    import ocd_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [COORD_BITS-1:0]   cfg_data,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_action,
    input  wire logic [4*COORD_BITS-1:0] s_coords,
    input  wire logic                    q_full,
    output logic                         q_push,
    output cmd_ctrl_t                    q_ctrl,
    output logic [4*COORD_BITS-1:0]      q_coords
);

    logic [COORD_BITS-1:0] x_min_reg, y_min_reg, x_max_reg, y_max_reg;
    logic [COLOR_W-1:0]    vis_color_reg, rej_color_reg;
    logic [COORD_BITS-1:0] x0, y0, x1, y1;
    logic [CODE_W-1:0]     c0, c1;
    line_class_t           cls;

    function automatic logic [CODE_W-1:0] outcode(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y,
        input logic [COORD_BITS-1:0] xmin,
        input logic [COORD_BITS-1:0] ymin,
        input logic [COORD_BITS-1:0] xmax,
        input logic [COORD_BITS-1:0] ymax
    );
        logic [CODE_W-1:0] c;
        c           = '0;
        c[OC_ABOVE] = (y > ymax);
        c[OC_BELOW] = (y < ymin);
        c[OC_RIGHT] = (x > xmax);
        c[OC_LEFT]  = (x < xmin);
        return c;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg     <= '0;
            y_min_reg     <= '0;
            x_max_reg     <= '1;
            y_max_reg     <= '1;
            vis_color_reg <= COLOR_W'(2);
            rej_color_reg <= COLOR_W'(4);
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_X_MIN:     x_min_reg     <= cfg_data;
                REG_Y_MIN:     y_min_reg     <= cfg_data;
                REG_X_MAX:     x_max_reg     <= cfg_data;
                REG_Y_MAX:     y_max_reg     <= cfg_data;
                REG_VIS_COLOR: vis_color_reg <= cfg_data[COLOR_W-1:0];
                REG_REJ_COLOR: rej_color_reg <= cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    assign x0 = s_coords[0*COORD_BITS +: COORD_BITS];
    assign y0 = s_coords[1*COORD_BITS +: COORD_BITS];
    assign x1 = s_coords[2*COORD_BITS +: COORD_BITS];
    assign y1 = s_coords[3*COORD_BITS +: COORD_BITS];

    assign c0 = outcode(x0, y0, x_min_reg, y_min_reg, x_max_reg, y_max_reg);
    assign c1 = outcode(x1, y1, x_min_reg, y_min_reg, x_max_reg, y_max_reg);

    always_comb begin
        if (c0 == '0 && c1 == '0) begin
            cls = CLASS_VISIBLE;
        end else if ((c0 & c1) != '0) begin
            cls = CLASS_REJECTED;
        end else begin
            cls = CLASS_CANDIDATE;
        end
    end

    always_comb begin
        q_ctrl.action     = s_action;
        q_ctrl.line_class = cls;
        q_ctrl.code_start = c0;
        q_ctrl.code_end   = c1;
        case (cls)
            CLASS_VISIBLE:  q_ctrl.color = vis_color_reg;
            CLASS_REJECTED: q_ctrl.color = rej_color_reg;
            default:        q_ctrl.color = '0;
        endcase
    end

    assign q_coords = s_coords;
    assign s_ready  = !q_full;
    assign q_push   = s_valid && !q_full;

endmodule

`default_nettype wire

/* hdl/ocd_div.sv */
// Bit-serial divider producing one signed DDA increment, (b - a) * 2^FRAC_BITS / steps,
// truncated toward zero. One quotient bit per cycle; uses no package.
`default_nettype none

module ocd_div #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [COORD_BITS-1:0] a,
    input  wire logic [COORD_BITS-1:0] b,
    input  wire logic [COORD_BITS-1:0] steps,
    output logic                       done,
    output logic [FRAC_BITS+1:0]       inc
);

    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    logic [COORD_BITS:0]   rem_reg, rem_next;
    logic [FRAC_BITS:0]    quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COORD_BITS-1:0] steps_reg, steps_next;
    logic                  neg_reg, neg_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  ge;
    logic [COORD_BITS:0]   rem_sub;
    logic [COORD_BITS-1:0] mag;
    logic [FRAC_BITS+1:0]  quo_ext;

    // The magnitude never exceeds the step count, so the quotient fits in
    // FRAC_BITS+1 bits and each partial remainder stays below the divisor.
    assign ge      = (rem_reg >= {1'b0, steps_reg});
    assign rem_sub = ge ? rem_reg - {1'b0, steps_reg} : rem_reg;
    assign mag     = (b < a) ? a - b : b - a;

    always_comb begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        steps_next = steps_reg;
        neg_next   = neg_reg;
        busy_next  = busy_reg;
        done_next  = done_reg;
        if (start) begin
            rem_next   = {1'b0, mag};
            quo_next   = '0;
            cnt_next   = CNT_W'(FRAC_BITS + 1);
            steps_next = steps;
            neg_next   = (b < a);
            busy_next  = 1'b1;
            done_next  = 1'b0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[FRAC_BITS-1:0], ge};
            rem_next = {rem_sub[COORD_BITS-1:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        steps_reg <= steps_next;
        neg_reg   <= neg_next;
    end

    assign quo_ext = {1'b0, quo_reg};
    assign inc     = neg_reg ? (FRAC_BITS+2)'(0) - quo_ext : quo_ext;
    assign done    = done_reg;

endmodule

`default_nettype wire

/* hdl/ocd_back.sv */
// Back end: line set-up, DDA stepping and the output register.
// Depends on ocd_pkg and ocd_div; drains commands from the command queue.
`default_nettype none

module ocd_back
    import ocd_pkg::*;
#(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_valid,
    output logic                         q_pop,
    input  wire cmd_ctrl_t               q_ctrl,
    input  wire logic [4*COORD_BITS-1:0] q_coords,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output line_class_t                  m_line_class,
    output logic [CODE_W-1:0]            m_code_start,
    output logic [CODE_W-1:0]            m_code_end,
    output logic                         m_pixel_valid,
    output logic [COORD_BITS-1:0]        m_pixel_x,
    output logic [COORD_BITS-1:0]        m_pixel_y,
    output logic [COLOR_W-1:0]           m_pixel_color,
    output logic                         m_last_pixel
);

    localparam int POS_W  = COORD_BITS + FRAC_BITS;
    localparam int INC_W  = FRAC_BITS + 2;
    localparam int LEFT_W = COORD_BITS + 1;

    typedef enum logic [1:0] {
        BK_RUN = 2'b01,
        BK_DIV = 2'b10
    } back_state_t;

    back_state_t           state_reg, state_next;
    logic [POS_W-1:0]      pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [INC_W-1:0]      inc_x_reg, inc_x_next, inc_y_reg, inc_y_next;
    logic [LEFT_W-1:0]     left_reg, left_next;
    logic [COLOR_W-1:0]    color_reg, color_next;
    line_class_t           class_reg, class_next;
    logic [CODE_W-1:0]     code_s_reg, code_s_next, code_e_reg, code_e_next;

    logic                  out_valid_reg, out_valid_next;
    line_class_t           out_class_reg, out_class_next;
    logic [CODE_W-1:0]     out_code_s_reg, out_code_s_next;
    logic [CODE_W-1:0]     out_code_e_reg, out_code_e_next;
    logic                  out_pv_reg, out_pv_next;
    logic [COORD_BITS-1:0] out_px_reg, out_px_next, out_py_reg, out_py_next;
    logic [COLOR_W-1:0]    out_color_reg, out_color_next;
    logic                  out_last_reg, out_last_next;

    logic [COORD_BITS-1:0] x0, y0, x1, y1, adx, ady, steps;
    logic                  out_free, div_start, div_done_x, div_done_y;
    logic [INC_W-1:0]      div_inc_x, div_inc_y;
    logic [POS_W-1:0]      inc_x_ext, inc_y_ext;

    assign x0 = q_coords[0*COORD_BITS +: COORD_BITS];
    assign y0 = q_coords[1*COORD_BITS +: COORD_BITS];
    assign x1 = q_coords[2*COORD_BITS +: COORD_BITS];
    assign y1 = q_coords[3*COORD_BITS +: COORD_BITS];

    assign adx   = (x1 > x0) ? x1 - x0 : x0 - x1;
    assign ady   = (y1 > y0) ? y1 - y0 : y0 - y1;
    assign steps = (adx > ady) ? adx : ady;

    assign inc_x_ext = {{(COORD_BITS-2){inc_x_reg[INC_W-1]}}, inc_x_reg};
    assign inc_y_ext = {{(COORD_BITS-2){inc_y_reg[INC_W-1]}}, inc_y_reg};

    assign out_free = !out_valid_reg || m_ready;

    ocd_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (x0),
        .b       (x1),
        .steps   (steps),
        .done    (div_done_x),
        .inc     (div_inc_x)
    );

    ocd_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (y0),
        .b       (y1),
        .steps   (steps),
        .done    (div_done_y),
        .inc     (div_inc_y)
    );

    always_comb begin
        state_next      = state_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        inc_x_next      = inc_x_reg;
        inc_y_next      = inc_y_reg;
        left_next       = left_reg;
        color_next      = color_reg;
        class_next      = class_reg;
        code_s_next     = code_s_reg;
        code_e_next     = code_e_reg;
        out_valid_next  = out_valid_reg;
        out_class_next  = out_class_reg;
        out_code_s_next = out_code_s_reg;
        out_code_e_next = out_code_e_reg;
        out_pv_next     = out_pv_reg;
        out_px_next     = out_px_reg;
        out_py_next     = out_py_reg;
        out_color_next  = out_color_reg;
        out_last_next   = out_last_reg;
        q_pop           = 1'b0;
        div_start       = 1'b0;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_RUN: begin
                if (q_valid && out_free) begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    out_pv_next    = 1'b0;
                    out_px_next    = '0;
                    out_py_next    = '0;
                    out_color_next = '0;
                    if (q_ctrl.action == ACT_STEP) begin
                        out_class_next  = class_reg;
                        out_code_s_next = '0;
                        out_code_e_next = '0;
                        if (left_reg == '0) begin
                            out_last_next = 1'b1;
                        end else begin
                            out_pv_next    = 1'b1;
                            out_px_next    = pos_x_reg[FRAC_BITS +: COORD_BITS];
                            out_py_next    = pos_y_reg[FRAC_BITS +: COORD_BITS];
                            out_color_next = color_reg;
                            out_last_next  = (left_reg == LEFT_W'(1));
                            pos_x_next     = pos_x_reg + inc_x_ext;
                            pos_y_next     = pos_y_reg + inc_y_ext;
                            left_next      = left_reg - LEFT_W'(1);
                        end
                    end else begin
                        class_next      = q_ctrl.line_class;
                        code_s_next     = q_ctrl.code_start;
                        code_e_next     = q_ctrl.code_end;
                        out_class_next  = q_ctrl.line_class;
                        out_code_s_next = q_ctrl.code_start;
                        out_code_e_next = q_ctrl.code_end;
                        pos_x_next      = {x0, {FRAC_BITS{1'b0}}};
                        pos_y_next      = {y0, {FRAC_BITS{1'b0}}};
                        color_next      = q_ctrl.color;
                        out_last_next   = 1'b1;
                        if (q_ctrl.line_class == CLASS_CANDIDATE || steps == '0) begin
                            left_next  = (q_ctrl.line_class == CLASS_CANDIDATE)
                                         ? '0 : {1'b0, steps};
                            inc_x_next = '0;
                            inc_y_next = '0;
                        end else begin
                            // The start result waits until both increments are known.
                            left_next      = {1'b0, steps};
                            div_start      = 1'b1;
                            out_valid_next = 1'b0;
                            state_next     = BK_DIV;
                        end
                    end
                end
            end
            BK_DIV: begin
                if (div_done_x && div_done_y && out_free) begin
                    inc_x_next      = div_inc_x;
                    inc_y_next      = div_inc_y;
                    out_valid_next  = 1'b1;
                    out_class_next  = class_reg;
                    out_code_s_next = code_s_reg;
                    out_code_e_next = code_e_reg;
                    out_pv_next     = 1'b0;
                    out_px_next     = '0;
                    out_py_next     = '0;
                    out_color_next  = '0;
                    out_last_next   = 1'b0;
                    state_next      = BK_RUN;
                end
            end
            default: begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_RUN;
            left_reg      <= '0;
            class_reg     <= CLASS_VISIBLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            class_reg     <= class_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_x_reg      <= pos_x_next;
        pos_y_reg      <= pos_y_next;
        inc_x_reg      <= inc_x_next;
        inc_y_reg      <= inc_y_next;
        color_reg      <= color_next;
        code_s_reg     <= code_s_next;
        code_e_reg     <= code_e_next;
        out_class_reg  <= out_class_next;
        out_code_s_reg <= out_code_s_next;
        out_code_e_reg <= out_code_e_next;
        out_pv_reg     <= out_pv_next;
        out_px_reg     <= out_px_next;
        out_py_reg     <= out_py_next;
        out_color_reg  <= out_color_next;
        out_last_reg   <= out_last_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_line_class  = out_class_reg;
    assign m_code_start  = out_code_s_reg;
    assign m_code_end    = out_code_e_reg;
    assign m_pixel_valid = out_pv_reg;
    assign m_pixel_x     = out_px_reg;
    assign m_pixel_y     = out_py_reg;
    assign m_pixel_color = out_color_reg;
    assign m_last_pixel  = out_last_reg;

endmodule

`default_nettype wire

/* hdl/ocd_checker.sv */
// Port-level checker for the line drawer core, attached by the bind at the end of this file.
// Depends on ocd_pkg and on the port names of the top level.
`default_nettype none

module ocd_checker
    import ocd_pkg::*;
#(
    parameter int COORD_BITS = 10
) (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [((2*COORD_BITS+CLASS_W+2*CODE_W+COLOR_W+7)/8)*8-1:0] m_axis_tdata,
    input wire logic [0:0] m_axis_tuser,
    input wire logic m_axis_tlast
);

    localparam int CODES_LO = CLASS_W;
    localparam int CODES_W  = 2 * CODE_W;
    localparam int PIX_LO   = CLASS_W + 2 * CODE_W;
    localparam int PIX_W    = 2 * COORD_BITS + COLOR_W;

    // A stalled result keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // The line class is never the unused code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[CLASS_W-1:0] != 2'd3)
        else $error("invalid line class");

    // A result without a pixel carries zero coordinates and colour.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[PIX_LO +: PIX_W] == '0)
        else $error("pixel fields set on a result without a pixel");

    // Pixels only come from visible or rejected lines and carry no outcodes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[CODES_LO +: CODES_W] == '0
            && m_axis_tdata[CLASS_W-1:0] != CLASS_CANDIDATE)
        else $error("pixel emitted with outcodes or for a clipping candidate");

endmodule

bind outcode_classify_dda_line_drawer_core ocd_checker #(
    .COORD_BITS (COORD_BITS)
) u_ocd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
